// ===== sv/rbsi_pkg.sv =====
// rbsi_pkg: shared constants, lane status type and request/result types for the ray/box slab test
// depends on nothing
package rbsi_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ExtW        = 31;
  localparam int unsigned NumAxes     = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [ExtW-1:0]   ext_t;

  // per-axis result handed from a lane to the merge stage
  typedef struct packed {
    logic   parallel;  // zero direction, no time limit
    logic   in_slab;   // origin within slab (parallel case)
    coord_t t_near;
    coord_t t_far;
  } lane_res_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    ext_t   extent_x;
    ext_t   extent_y;
    ext_t   extent_z;
  } ray_req_t;

  typedef struct packed {
    logic   hit;
    coord_t t_hit;
  } hit_res_t;

endpackage

// ===== sv/rbsi_if.sv =====
// rbsi_if: valid/ready channels for requests and results
// depends on rbsi_pkg
interface rbsi_req_if;
  logic               valid;
  logic               ready;
  rbsi_pkg::ray_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbsi_res_if;
  logic               valid;
  logic               ready;
  rbsi_pkg::hit_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rbsi_div.sv =====
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// depends on rbsi_pkg
module rbsi_div #(
  parameter int unsigned NumW = 56,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,   // magnitude
  input  logic [DenW-1:0] den_i,   // magnitude, nonzero
  output logic [NumW-1:0] quo_o
);
  import rbsi_pkg::*;

  logic [NumW-1:0] num_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];
  logic [DenW:0]   rem_q [NumW+1];

  always_comb begin
    num_q[0] = num_i;
    den_q[0] = den_i;
    rem_q[0] = '0;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW:0]   rem_sh;
    assign rem_sh = {rem_q[s][DenW-1:0], num_q[s][NumW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        if (!trial[DenW+1]) begin
          rem_q[s+1] <= trial[DenW:0];
          num_q[s+1] <= {num_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= rem_sh;
          num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = num_q[NumW];
endmodule

// ===== sv/rbsi_lane.sv =====
// rbsi_lane: one axis of the slab test, bounds, two divisions and ordering
// depends on rbsi_pkg, rbsi_div
module rbsi_lane #(
  parameter int unsigned FracBits = rbsi_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  rbsi_pkg::coord_t    origin_i,
  input  rbsi_pkg::coord_t    dir_i,
  input  rbsi_pkg::coord_t    center_i,
  input  rbsi_pkg::ext_t      extent_i,
  output rbsi_pkg::lane_res_t res_o
);
  import rbsi_pkg::*;

  localparam int unsigned NumW  = CoordW + 2 + FracBits; // |lo-o|*2^F

  logic signed [CoordW+1:0] lo_w, hi_w;
  logic signed [CoordW:0]   lo_s, hi_s;
  logic signed [CoordW:0]   o_x;

  // stage 0: saturated bounds
  coord_t lo_q, hi_q, o_q, d_q;

  always_comb begin
    lo_w = {{2{center_i[CoordW-1]}}, center_i} - {4'b0000, extent_i[ExtW-1:1]};
    hi_w = {{2{center_i[CoordW-1]}}, center_i} + {4'b0000, extent_i[ExtW-1:1]};
  end

  function automatic coord_t sat(input logic signed [CoordW+1:0] v);
    if (v > $signed({2'b00, {1'b0, {(CoordW-1){1'b1}}}}))
      return {1'b0, {(CoordW-1){1'b1}}};
    if (v < $signed({2'b11, {1'b1, {(CoordW-1){1'b0}}}}))
      return {1'b1, {(CoordW-1){1'b0}}};
    return v[CoordW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= sat(lo_w);
      hi_q <= sat(hi_w);
      o_q  <= origin_i;
      d_q  <= dir_i;
    end
  end

  // stage 1: differences, signs, magnitudes
  assign lo_s = {lo_q[CoordW-1], lo_q};
  assign hi_s = {hi_q[CoordW-1], hi_q};
  assign o_x  = {o_q[CoordW-1], o_q};

  logic signed [CoordW:0] n1, n2;
  assign n1 = lo_s - o_x;
  assign n2 = hi_s - o_x;

  logic [NumW-1:0] m1_q, m2_q;
  logic [CoordW-1:0] dm_q;
  logic s1_q, s2_q, par_q, in_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= {1'b0, (n1[CoordW] ? -n1 : n1), {FracBits{1'b0}}};
      m2_q  <= {1'b0, (n2[CoordW] ? -n2 : n2), {FracBits{1'b0}}};
      dm_q  <= d_q[CoordW-1] ? -d_q : d_q;
      s1_q  <= n1[CoordW] ^ d_q[CoordW-1];
      s2_q  <= n2[CoordW] ^ d_q[CoordW-1];
      par_q <= (d_q == '0);
      in_q  <= !((o_q < lo_q) || (o_q > hi_q));
    end
  end

  logic [NumW-1:0] q1, q2;
  logic [CoordW-1:0] dm_div;
  assign dm_div = par_q ? {{(CoordW-1){1'b0}}, 1'b1} : dm_q;

  rbsi_div #(.NumW(NumW), .DenW(CoordW)) u_div1 (
    .clk_i, .en_i, .num_i(m1_q), .den_i(dm_div), .quo_o(q1));
  rbsi_div #(.NumW(NumW), .DenW(CoordW)) u_div2 (
    .clk_i, .en_i, .num_i(m2_q), .den_i(dm_div), .quo_o(q2));

  // side info rides alongside the divider
  logic [3:0] side_q [NumW+1];
  always_comb side_q[0] = {s1_q, s2_q, par_q, in_q};
  for (genvar s = 0; s < NumW; s++) begin : g_side
    always_ff @(posedge clk_i) if (en_i) side_q[s+1] <= side_q[s];
  end

  function automatic coord_t sat_mag(input logic [NumW-1:0] m, input logic neg);
    if (neg) begin
      if (m >= NumW'({1'b1, {(CoordW-1){1'b0}}})) return {1'b1, {(CoordW-1){1'b0}}};
      return coord_t'(-m[CoordW-1:0]);
    end
    if (m > NumW'({(CoordW-1){1'b1}})) return {1'b0, {(CoordW-1){1'b1}}};
    return m[CoordW-1:0];
  endfunction

  coord_t t1, t2;
  assign t1 = sat_mag(q1, side_q[NumW][3]);
  assign t2 = sat_mag(q2, side_q[NumW][2]);

  // final stage: order the pair
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.parallel <= side_q[NumW][1];
      res_o.in_slab  <= side_q[NumW][0];
      res_o.t_near   <= (t1 > t2) ? t2 : t1;
      res_o.t_far    <= (t1 > t2) ? t1 : t2;
    end
  end
endmodule

// ===== sv/rbsi_merge.sv =====
// rbsi_merge: combines the three lane intervals into hit and distance
// depends on rbsi_pkg
module rbsi_merge (
  input  logic                clk_i,
  input  logic                en_i,
  input  rbsi_pkg::lane_res_t lane_i [rbsi_pkg::NumAxes],
  output rbsi_pkg::hit_res_t  res_o
);
  import rbsi_pkg::*;

  coord_t tmin, tmax;
  logic   ok;

  always_comb begin
    tmin = {1'b1, {(CoordW-1){1'b0}}};
    tmax = {1'b0, {(CoordW-1){1'b1}}};
    ok   = 1'b1;
    for (int a = 0; a < NumAxes; a++) begin
      if (lane_i[a].parallel) begin
        ok = ok & lane_i[a].in_slab;
      end else begin
        if (lane_i[a].t_near > tmin) tmin = lane_i[a].t_near;
        if (lane_i[a].t_far  < tmax) tmax = lane_i[a].t_far;
      end
    end
    // order-independent: empty after any axis stays empty
    ok = ok && (tmin <= tmax) && !tmax[CoordW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.hit   <= ok;
      res_o.t_hit <= !ok ? '0 : (tmin[CoordW-1] ? tmax : tmin);
    end
  end
endmodule

// ===== sv/ray_box_slab_intersect.sv =====
// channel | dir | payload
// req_if  | in  | ray origin, direction, box center and full size (Q16.16)
// res_if  | out | hit flag and hit distance
// one request per cycle while the result is not stalled; stages in order: a bound
// stage, a difference stage, one divider stage per quotient bit, ordering and merge
// the pipeline advances whenever the output register is empty or taken;
// a stalled result holds the whole pipe, valid bits clear on rst_ni
// depends on rbsi_pkg, rbsi_if, rbsi_lane, rbsi_merge
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = rbsi_pkg::FracBitsDef
) (
  input logic   clk_i,
  input logic   rst_ni,
  rbsi_req_if.sink   req_if,
  rbsi_res_if.source res_if
);
  import rbsi_pkg::*;

  localparam int unsigned Lat = FRAC_BITS + CoordW + 6;

  logic en;
  logic [Lat-1:0] vld_q;

  assign en           = !res_if.valid || res_if.ready;
  assign req_if.ready = en;
  assign res_if.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], req_if.valid};
    end
  end

  lane_res_t lane_res [NumAxes];
  coord_t    org [NumAxes], dir [NumAxes], ctr [NumAxes];
  ext_t      ext [NumAxes];

  assign org = '{req_if.data.origin_x, req_if.data.origin_y, req_if.data.origin_z};
  assign dir = '{req_if.data.dir_x, req_if.data.dir_y, req_if.data.dir_z};
  assign ctr = '{req_if.data.center_x, req_if.data.center_y, req_if.data.center_z};
  assign ext = '{req_if.data.extent_x, req_if.data.extent_y, req_if.data.extent_z};

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    rbsi_lane #(.FracBits(FRAC_BITS)) u_lane (
      .clk_i, .en_i(en),
      .origin_i(org[a]), .dir_i(dir[a]), .center_i(ctr[a]), .extent_i(ext[a]),
      .res_o(lane_res[a]));
  end

  rbsi_merge u_merge (
    .clk_i, .en_i(en), .lane_i(lane_res), .res_o(res_if.data));
endmodule

// ===== tb/sv/ray_box_slab_intersect_test.sv =====
// ray_box_slab_intersect_test: checks hit flag and hit time of the slab unit against a
// 64-bit behavioral predictor, under random idle and stall phases
// depends on rbsi_pkg, rbsi_if, ray_box_slab_intersect
module ray_box_slab_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  localparam int unsigned FracBits  = FracBitsDef;
  localparam int unsigned Latency   = FracBits + 38;
  localparam int unsigned WatchLim  = 20000;
  localparam int unsigned NumRandom = 1530;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rbsi_req_if req_if ();
  rbsi_res_if res_if ();

  ray_box_slab_intersect #(.FRAC_BITS(FracBits)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if.sink),
    .res_if (res_if.source)
  );

  ray_req_t pending_rays[$];
  hit_res_t expected_hits[$];
  int       n_errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_send = 1'b0;
  bit       all_queued = 1'b0;
  int       quiet_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  // narrows [tlo, thi] by one axis, returns 0 on a miss
  function automatic bit narrow_slab(coord_t o, coord_t d, coord_t c, ext_t e,
                                     inout longint tlo, inout longint thi);
    longint half, lo, hi, t1, t2, sw;
    half = longint'(e >> 1);
    lo = clamp32(longint'(c) - half);
    hi = clamp32(longint'(c) + half);
    if (d == 0) return !(longint'(o) < lo || longint'(o) > hi);
    t1 = clamp32(((lo - longint'(o)) <<< FracBits) / longint'(d));
    t2 = clamp32(((hi - longint'(o)) <<< FracBits) / longint'(d));
    if (t1 > t2) begin
      sw = t1; t1 = t2; t2 = sw;
    end
    if (t1 > tlo) tlo = t1;
    if (t2 < thi) thi = t2;
    return tlo <= thi;
  endfunction

  function automatic hit_res_t slab_hit(ray_req_t r);
    longint   tlo, thi;
    bit       ok;
    hit_res_t h;
    tlo = -64'sd2147483648;
    thi = 64'sd2147483647;
    ok = narrow_slab(r.origin_x, r.dir_x, r.center_x, r.extent_x, tlo, thi);
    if (ok) ok = narrow_slab(r.origin_y, r.dir_y, r.center_y, r.extent_y, tlo, thi);
    if (ok) ok = narrow_slab(r.origin_z, r.dir_z, r.center_z, r.extent_z, tlo, thi);
    if (ok && thi < 0) ok = 1'b0;
    h.hit = ok;
    h.t_hit = !ok ? '0 : (tlo >= 0 ? coord_t'(tlo) : coord_t'(thi));
    return h;
  endfunction

  task automatic report_mismatch(string what, hit_res_t got, hit_res_t want);
    $display("mismatch %s: got hit=%0b t=%0d, want hit=%0b t=%0d",
             what, got.hit, got.t_hit, want.hit, want.t_hit);
    n_errors++;
  endtask

  task automatic queue_ray(ray_req_t r);
    pending_rays = {pending_rays, r};
  endtask

  // mostly small coordinates so hits are common, sometimes full range
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1:    return coord_t'($urandom);
      2:       return coord_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
      default: return coord_t'($signed($urandom_range(0, 32'h00a0_0000)) - 32'sh0050_0000);
    endcase
  endfunction

  function automatic coord_t rand_dir();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(1, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  function automatic ext_t rand_ext();
    case ($urandom_range(0, 7))
      0:       return ext_t'($urandom);
      1:       return $urandom_range(0, 1) ? '0 : '1;
      default: return ext_t'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  // random box and ray; half of the time the ray is aimed at the box center
  function automatic ray_req_t rand_ray();
    ray_req_t r;
    r.center_x = rand_coord(); r.center_y = rand_coord(); r.center_z = rand_coord();
    r.extent_x = rand_ext(); r.extent_y = rand_ext(); r.extent_z = rand_ext();
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
    if ($urandom_range(0, 1)) begin
      r.dir_x = coord_t'((longint'(r.center_x) - longint'(r.origin_x)) >>> 4);
      r.dir_y = coord_t'((longint'(r.center_y) - longint'(r.origin_y)) >>> 4);
      r.dir_z = coord_t'((longint'(r.center_z) - longint'(r.origin_z)) >>> 4);
    end
    return r;
  endfunction

  function automatic ray_req_t unit_ray(coord_t ox, coord_t dx, coord_t cx, ext_t ex);
    ray_req_t r;
    r = '{default: '0};
    r.origin_x = ox; r.dir_x = dx; r.center_x = cx; r.extent_x = ex;
    r.extent_y = 31'h0002_0000; r.extent_z = 31'h0002_0000;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_rays.size() > 0 && !hold_send &&
          $urandom_range(1, 100) > send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= pending_rays.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // expected results are taken when the request is accepted
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      expected_hits = {expected_hits, slab_hit(req_if.data)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else         res_if.ready <= $urandom_range(1, 100) > recv_stall_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    hit_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", res_if.data, '0);
      end else begin
        want = expected_hits.pop_front();
        if (res_if.data.hit !== want.hit) report_mismatch("hit", res_if.data, want);
        else if (res_if.data.t_hit !== want.t_hit) report_mismatch("t_hit", res_if.data, want);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else if (pending_rays.size() > 0 || expected_hits.size() > 0 || !all_queued)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLim) begin
      $display("watchdog expired");
      $display("ray_box_slab_intersect_test: errors");
      $finish;
    end
  end

  task automatic drain();
    while (pending_rays.size() > 0 || req_if.valid || expected_hits.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    ray_req_t r;
    int       phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: hits, misses, parallel in/out/on face, odd extent, extremes
    queue_ray(unit_ray(32'shfffb_0000, 32'sh0001_0000, '0, 31'h0002_0000));
    queue_ray(unit_ray(32'sh0005_0000, 32'sh0001_0000, '0, 31'h0002_0000));
    queue_ray(unit_ray(32'sh0005_0000, 32'shffff_0000, '0, 31'h0002_0000));
    queue_ray(unit_ray('0, 32'sh0001_0000, '0, 31'h0002_0000));
    queue_ray(unit_ray('0, '0, '0, 31'h0002_0000));
    queue_ray(unit_ray(32'sh0001_0000, '0, '0, 31'h0002_0000));
    queue_ray(unit_ray(32'sh0001_0001, '0, '0, 31'h0002_0001));
    queue_ray(unit_ray(32'sh0001_0000, '0, '0, 31'h0002_0003));
    queue_ray(unit_ray(32'sh8000_0000, 32'sh0000_0001, 32'sh7fff_ffff, '1));
    queue_ray(unit_ray(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, '1));
    queue_ray(unit_ray(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, '0));
    queue_ray(unit_ray(32'sh7fff_ffff, 32'shffff_ffff, 32'sh7fff_ffff, '1));
    queue_ray(unit_ray('0, 32'sh0001_0000, 32'sh7fff_ffff, '1));
    r = unit_ray(32'shfffb_0000, 32'sh0001_0000, '0, 31'h0002_0000);
    r.origin_y = 32'sh0003_0000;
    queue_ray(r);
    r.dir_y = 32'sh0001_0000;
    queue_ray(r);
    r = '{default: '1};
    queue_ray(r);
    queue_ray('0);
    drain();

    // random phases, the first one pausing until everything is back
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 81 : 14) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 81 : 14) : 0;
      repeat (NumRandom / 4) queue_ray(rand_ray());
      if (phase == 0) begin
        repeat (100) @(posedge clk_i);
        hold_send = 1'b1;
        while (req_if.valid || expected_hits.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    all_queued = 1'b1;
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0) $display("ray_box_slab_intersect_test: clean");
    else $display("ray_box_slab_intersect_test: errors");
    $finish;
  end
endmodule

// ===== files.f =====
sv/rbsi_pkg.sv
sv/rbsi_if.sv
sv/rbsi_div.sv
sv/rbsi_lane.sv
sv/rbsi_merge.sv
sv/ray_box_slab_intersect.sv
tb/sv/ray_box_slab_intersect_test.sv
